// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the debounced button block.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with a message.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dbt_pkg.sv -----
// Package for the debounced button block: command, mode, unit and register codes,
// and the microcode types and program of the sequencer. No dependencies.
package dbt_pkg;

  // Input commands.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SENT   = 2'd1;
  localparam logic [1:0] CMD_ASSIGN = 2'd2;

  // Operating modes.
  localparam logic [1:0] MODE_TOGGLE  = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_TAP     = 2'd2;

  // Tap interval units.
  localparam logic [2:0] UNIT_MS  = 3'd0;
  localparam logic [2:0] UNIT_S   = 3'd1;
  localparam logic [2:0] UNIT_HZ  = 3'd2;
  localparam logic [2:0] UNIT_BPM = 3'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_UNIT      = 3'd1;
  localparam logic [2:0] REG_SCALE_MIN = 3'd2;
  localparam logic [2:0] REG_SCALE_MAX = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd4;
  localparam logic [2:0] REG_TAP_LIMIT = 3'd5;

  // Register reset values.
  localparam logic [31:0] SCALE_MAX_RST = 32'h0001_0000;
  localparam logic [15:0] TAP_LIMIT_RST = 16'd2000;

  // Conversion constants.
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned MS_PER_MIN = 60000;
  localparam int unsigned HALF_S     = 500;

  // Sequencer.
  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH  = 4'd1;
  localparam logic [STEP_W-1:0] ST_TIME      = 4'd2;
  localparam logic [STEP_W-1:0] ST_DEBOUNCE  = 4'd3;
  localparam logic [STEP_W-1:0] ST_APPLY     = 4'd4;
  localparam logic [STEP_W-1:0] ST_DIV_START = 4'd5;
  localparam logic [STEP_W-1:0] ST_DIV_WAIT  = 4'd6;
  localparam logic [STEP_W-1:0] ST_CLAMP     = 4'd7;
  localparam logic [STEP_W-1:0] ST_OTHER     = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT      = 4'd9;

  typedef enum logic [2:0] {
    OP_LATCH,
    OP_NONE,
    OP_TIME,
    OP_DEBOUNCE,
    OP_APPLY,
    OP_DIV_START,
    OP_CLAMP,
    OP_OTHER
  } op_e;

  // OP_EMIT shares the encoding space through its own flag below.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_NOT_TICK,
    COND_TRIG_HELD,
    COND_NO_CONV,
    COND_DIV_BUSY,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e               op;
    logic              emit;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  // The program: when the condition holds the step jumps to target, otherwise it
  // moves on to the next step, or back to idle after the last one.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_NONE, emit: 1'b0, cond: COND_NONE, target: ST_IDLE, last: 1'b0};
    case (addr)
      ST_IDLE: begin
        w.op = OP_LATCH;    w.cond = COND_NO_ITEM;   w.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        w.cond = COND_NOT_TICK;  w.target = ST_OTHER;
      end
      ST_TIME: begin
        w.op = OP_TIME;     w.cond = COND_TRIG_HELD; w.target = ST_EMIT;
      end
      ST_DEBOUNCE: begin
        w.op = OP_DEBOUNCE;
      end
      ST_APPLY: begin
        w.op = OP_APPLY;    w.cond = COND_NO_CONV;   w.target = ST_EMIT;
      end
      ST_DIV_START: begin
        w.op = OP_DIV_START;
      end
      ST_DIV_WAIT: begin
        w.cond = COND_DIV_BUSY;  w.target = ST_DIV_WAIT;
      end
      ST_CLAMP: begin
        w.op = OP_CLAMP;    w.cond = COND_ALWAYS;    w.target = ST_EMIT;
      end
      ST_OTHER: begin
        w.op = OP_OTHER;
      end
      ST_EMIT: begin
        w.emit = 1'b1;      w.cond = COND_OUT_BLOCKED; w.target = ST_EMIT;
        w.last = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS;    w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/dbt_div.sv -----
// Restoring divider for the tap interval conversion, one quotient bit per cycle.
// Self-contained; a zero divisor yields an all-ones quotient.
module dbt_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_shift;
  logic             fits;

  // The numerator shifts out of the top of quot_q while quotient bits enter below.
  assign rem_shift = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      quot_d = num_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      rem_d  = fits ? rem_shift - {1'b0, den_q} : rem_shift;
      quot_d = {quot_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/debounced_button_tap_tempo.sv -----
// Top level of the debounced button with toggle, trigger and tap-tempo modes.
// Depends on dbt_pkg, dbt_div and assert_macros.svh.
//
// Usage. One input transfer carries a command (cmd_i) and a raw button level
// (level_i): a one-millisecond sample tick, a message-sent notice or an
// assignment-applied notice. Every accepted transfer produces exactly one
// output transfer with the current value (unsigned Q16.16), the saved bit and
// the tap-armed flag. Both channels use valid and stall; a transfer happens at
// a rising edge with valid high and stall low.
// Sequencing. A small microcoded sequencer walks each item through a short
// program: a notice is applied and emitted; a tick counts time and, unless a
// trigger is held, is debounced and applied; one that closes a tap interval
// then passes the restoring divider, one quotient bit per cycle, and a clamp.
// One item is in hand at a time: the next is taken once the last is emitted.
// Stall. A stalled result holds in the output register; the next item is still
// taken and worked through, then waits at the emit step with the input stalled.
// Reset. rst_ni resets all but the payload registers and loads the register
// reset values; the block is ready for input in the first cycle after reset.
// The user is to write configuration over the APB port only while the block
// is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module debounced_button_tap_tempo #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        level_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic        latched_o,
  output logic        tap_armed_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import dbt_pkg::*;

  localparam int unsigned TAP_W = COUNT_BITS + 1;
  localparam int unsigned CMP_W = (TAP_W > 16) ? TAP_W : 16;
  localparam int unsigned NUM_W = ((TAP_W > 16) ? TAP_W : 16) + FRAC_BITS + 1;
  localparam int unsigned DEN_W = (TAP_W > 10) ? TAP_W : 10;
  localparam int unsigned QX_W  = (NUM_W > 33) ? NUM_W : 33;
  localparam logic [31:0] VALUE_TOL = 32'((64'd1 << FRAC_BITS) / 64'd100);

  // Configuration registers.
  logic [1:0]  mode_q;
  logic [2:0]  unit_q;
  logic [31:0] scale_min_q;
  logic [31:0] scale_max_q;
  logic [15:0] debounce_q;
  logic [15:0] tap_limit_q;

  // Sequencer and datapath state.
  logic [STEP_W-1:0]     step_q, step_d;
  ucode_t                uc;
  logic                  cond_hit;
  logic [1:0]            cmd_q;
  logic                  level_q;
  logic                  prev_q, prev_d;
  logic                  stable_q, stable_d;
  logic                  saved_q, saved_d;
  logic                  armed_q, armed_d;
  logic                  released_q, released_d;
  logic [COUNT_BITS-1:0] hold_q, hold_d;
  logic [TAP_W-1:0]      tap_q, tap_d;
  logic [31:0]           value_q, value_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_value_q;
  logic                  out_latched_q, out_armed_q;
  logic                  out_load;

  // Combinational helpers.
  logic                  armed_eff;
  logic                  need_conv;
  logic                  div_start;
  logic                  div_busy;
  logic [NUM_W-1:0]      div_quot;
  logic [QX_W-1:0]       quot_ext;
  logic [31:0]           quot_sat;
  logic [NUM_W-1:0]      t_shift;
  logic [NUM_W-1:0]      t_half;
  logic [31:0]           diff;
  logic [COUNT_BITS-1:0] hold_eff;
  logic                  cfg_write;

  //--------------------------------------------------------------------------
  // Configuration port. Registers sit at byte addresses 4*i; pready is tied high.
  //--------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TOGGLE;
      unit_q      <= UNIT_MS;
      scale_min_q <= '0;
      scale_max_q <= SCALE_MAX_RST;
      debounce_q  <= '0;
      tap_limit_q <= TAP_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_MODE:      mode_q      <= pwdata[1:0];
        REG_UNIT:      unit_q      <= pwdata[2:0];
        REG_SCALE_MIN: scale_min_q <= pwdata;
        REG_SCALE_MAX: scale_max_q <= pwdata;
        REG_DEBOUNCE:  debounce_q  <= pwdata[15:0];
        REG_TAP_LIMIT: tap_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:      prdata = {30'd0, mode_q};
      REG_UNIT:      prdata = {29'd0, unit_q};
      REG_SCALE_MIN: prdata = scale_min_q;
      REG_SCALE_MAX: prdata = scale_max_q;
      REG_DEBOUNCE:  prdata = {16'd0, debounce_q};
      REG_TAP_LIMIT: prdata = {16'd0, tap_limit_q};
      default:       prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer: fetch the control word, evaluate its jump condition.
  //--------------------------------------------------------------------------
  assign uc         = ucode_rom(step_q);
  assign in_stall_o = step_q != ST_IDLE;

  // A tap closes an interval when it is a release in tap mode with the
  // measurement still armed after the limit check.
  assign armed_eff = armed_q && !(CMP_W'(tap_q) > CMP_W'(tap_limit_q));
  assign need_conv = (mode_q == MODE_TAP) && released_q && armed_eff;

  always_comb begin
    case (uc.cond)
      COND_NONE:        cond_hit = 1'b0;
      COND_ALWAYS:      cond_hit = 1'b1;
      COND_NO_ITEM:     cond_hit = !in_valid_i;
      COND_NOT_TICK:    cond_hit = cmd_q != CMD_TICK;
      COND_TRIG_HELD:   cond_hit = (mode_q == MODE_TRIGGER) && saved_q;
      COND_NO_CONV:     cond_hit = !need_conv;
      COND_DIV_BUSY:    cond_hit = div_busy;
      COND_OUT_BLOCKED: cond_hit = out_valid_q && out_stall_i;
      default:          cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      step_d = uc.target;
    end else if (uc.last) begin
      step_d = ST_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  //--------------------------------------------------------------------------
  // Datapath, driven by the operation field of the control word.
  //--------------------------------------------------------------------------
  assign t_shift   = NUM_W'(tap_q) << FRAC_BITS;
  assign t_half    = NUM_W'(tap_q >> 1);
  assign diff      = (value_q >= scale_max_q) ? value_q - scale_max_q
                                              : scale_max_q - value_q;
  assign hold_eff  = (level_q != prev_q) ? '0 : hold_q;
  assign quot_ext  = QX_W'(div_quot);
  assign quot_sat  = (quot_ext > QX_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quot_ext[31:0];
  assign div_start = uc.op == OP_DIV_START;
  assign out_load  = uc.emit && !(out_valid_q && out_stall_i);

  always_comb begin
    prev_d     = prev_q;
    stable_d   = stable_q;
    saved_d    = saved_q;
    armed_d    = armed_q;
    released_d = released_q;
    hold_d     = hold_q;
    tap_d      = tap_q;
    value_d    = value_q;
    num_d      = num_q;
    den_d      = den_q;

    case (uc.op)
      OP_TIME: begin
        // Time passes on every tick, whatever else the tick does.
        if (hold_q != '1) begin
          hold_d = hold_q + 1'b1;
        end
        if (tap_q != '1) begin
          tap_d = tap_q + 1'b1;
        end
      end

      OP_DEBOUNCE: begin
        released_d = 1'b0;
        if (debounce_q != '0) begin
          hold_d = hold_eff;
          if ((CMP_W'(hold_eff) >= CMP_W'(debounce_q)) && (stable_q != level_q)) begin
            stable_d   = level_q;
            released_d = !level_q;
            saved_d    = saved_q ^ !level_q;
          end
        end else if (level_q != prev_q) begin
          released_d = 1'b1;
          saved_d    = !saved_q;
        end
        prev_d = level_q;
      end

      OP_APPLY: begin
        case (mode_q)
          MODE_TRIGGER: begin
            if (saved_q) begin
              value_d = scale_max_q;
            end
          end
          MODE_TOGGLE: begin
            value_d = saved_q ? scale_max_q : scale_min_q;
          end
          MODE_TAP: begin
            armed_d = armed_eff;
            if (released_q) begin
              armed_d = 1'b1;
              tap_d   = '0;
              // Operands for the conversion, used only when the interval closes.
              case (unit_q)
                UNIT_MS: begin
                  num_d = t_shift;
                  den_d = DEN_W'(1);
                end
                UNIT_S: begin
                  num_d = t_shift + NUM_W'(HALF_S);
                  den_d = DEN_W'(MS_PER_S);
                end
                UNIT_HZ: begin
                  num_d = (NUM_W'(MS_PER_S) << FRAC_BITS) + t_half;
                  den_d = DEN_W'(tap_q);
                end
                UNIT_BPM: begin
                  num_d = (NUM_W'(MS_PER_MIN) << FRAC_BITS) + t_half;
                  den_d = DEN_W'(tap_q);
                end
                default: begin
                  num_d = '0;
                  den_d = DEN_W'(1);
                end
              endcase
            end
          end
          default: ;
        endcase
      end

      OP_CLAMP: begin
        if (quot_sat > scale_max_q) begin
          value_d = scale_max_q;
        end else if (quot_sat < scale_min_q) begin
          value_d = scale_min_q;
        end else begin
          value_d = quot_sat;
        end
      end

      OP_OTHER: begin
        case (cmd_q)
          CMD_SENT: begin
            if (mode_q == MODE_TRIGGER) begin
              saved_d = 1'b0;
            end
          end
          CMD_ASSIGN: begin
            if (mode_q == MODE_TOGGLE) begin
              saved_d = diff < VALUE_TOL;
            end else if (mode_q != MODE_TAP) begin
              saved_d = 1'b0;
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      prev_q      <= 1'b0;
      stable_q    <= 1'b0;
      saved_q     <= 1'b0;
      armed_q     <= 1'b0;
      released_q  <= 1'b0;
      hold_q      <= '1;
      tap_q       <= '0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      prev_q      <= prev_d;
      stable_q    <= stable_d;
      saved_q     <= saved_d;
      armed_q     <= armed_d;
      released_q  <= released_d;
      hold_q      <= hold_d;
      tap_q       <= tap_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (uc.op == OP_LATCH) begin
      cmd_q   <= cmd_i;
      level_q <= level_i;
    end
    num_q <= num_d;
    den_q <= den_d;
    if (out_load) begin
      out_value_q   <= value_q;
      out_latched_q <= saved_q;
      out_armed_q   <= armed_q;
    end
  end

  dbt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign latched_o   = out_latched_q;
  assign tap_armed_o = out_armed_q;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_div_in_wait, div_busy, step_q == ST_DIV_WAIT,
                  "divider running outside its wait step")
  `ASSERT_NEXT(a_emit_done, out_load, out_valid_q && (step_q == ST_IDLE),
               "emit step did not deliver the result and return to idle")
  `ASSERT_CLK(a_arm_in_apply, $rose(armed_q) |-> ($past(step_q) == ST_APPLY),
              "tap measurement armed outside the apply step")

endmodule
